// ----- sv/infix_to_postfix_operator_stack_defines.svh -----
// ----------------------------------------------------------------------------
// infix_to_postfix_operator_stack_defines.svh
// Assertion macros for the operator-stack converter.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_OPERATOR_STACK_DEFINES_SVH
`define INFIX_TO_POSTFIX_OPERATOR_STACK_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset
`define ITOPS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itops: same-cycle check failed");
// Next-cycle implication
`define ITOPS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itops: next-cycle check failed");
`else
`define ITOPS_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ITOPS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ----- sv/itops_pkg.sv -----
// ----------------------------------------------------------------------------
// itops_pkg
// Shared constants, codes, precedence lookup and link types of the converter.
// ----------------------------------------------------------------------------
package itops_pkg;

   // Sizes
   localparam int STACK_DEPTH  = 32;
   localparam int OPERAND_BITS = 16;
   localparam int ADDR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

   // Command codes
   localparam logic [1:0] CMD_OPERAND  = 2'd0;
   localparam logic [1:0] CMD_OPERATOR = 2'd1;
   localparam logic [1:0] CMD_END      = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_OPERAND  = 2'd0;
   localparam logic [1:0] KIND_OPERATOR = 2'd1;
   localparam logic [1:0] KIND_ERROR    = 2'd2;
   localparam logic [1:0] KIND_END      = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_RPAREN    = 2'd1;
   localparam logic [1:0] ERR_NO_LPAREN = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

   // Operator codes
   localparam logic [3:0] OP_NOT    = 4'd0;
   localparam logic [3:0] OP_MUL    = 4'd1;
   localparam logic [3:0] OP_DIV    = 4'd2;
   localparam logic [3:0] OP_MOD    = 4'd3;
   localparam logic [3:0] OP_ADD    = 4'd4;
   localparam logic [3:0] OP_SUB    = 4'd5;
   localparam logic [3:0] OP_LT     = 4'd6;
   localparam logic [3:0] OP_GT     = 4'd7;
   localparam logic [3:0] OP_LE     = 4'd8;
   localparam logic [3:0] OP_GE     = 4'd9;
   localparam logic [3:0] OP_EQ     = 4'd10;
   localparam logic [3:0] OP_NE     = 4'd11;
   localparam logic [3:0] OP_AND    = 4'd12;
   localparam logic [3:0] OP_OR     = 4'd13;
   localparam logic [3:0] OP_ASSIGN = 4'd14;
   localparam logic [3:0] OP_LPAREN = 4'd15;

   // Stack write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [3:0]        data;
   } stack_wr_type;

   // Result offered by the sequencer; close marks a quiet end of an item
   typedef struct packed {
      logic                    valid;
      logic                    close;
      logic [1:0]              kind;
      logic [3:0]              op;
      logic [OPERAND_BITS-1:0] operand;
      logic [1:0]              err;
      logic                    fin;
   } put_type;

   // Sequencer status
   typedef struct packed {
      logic             idle;
      logic [CNT_W-1:0] count;
   } seq_status_type;

   // Precedence number: lower binds tighter
   function automatic logic [3:0] prec_of(input logic [3:0] code);
      logic [3:0] p;
      case (code)
         OP_NOT:                          p = 4'd1;
         OP_MUL, OP_DIV, OP_MOD:          p = 4'd2;
         OP_ADD, OP_SUB:                  p = 4'd3;
         OP_LT, OP_GT, OP_LE, OP_GE:      p = 4'd4;
         OP_EQ, OP_NE:                    p = 4'd5;
         OP_AND:                          p = 4'd6;
         OP_OR:                           p = 4'd7;
         OP_ASSIGN:                       p = 4'd8;
         OP_LPAREN:                       p = 4'd9;
         default:                         p = 4'd9;
      endcase
      return p;
   endfunction

endpackage

// ----- sv/itops_req_if.sv -----
// ----------------------------------------------------------------------------
// itops_req_if
// Token channel: valid/ready handshake with one token per beat.
// ----------------------------------------------------------------------------
interface itops_req_if;
   import itops_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [1:0]              command;
   logic [3:0]              operator_code;
   logic                    is_right_paren;
   logic [OPERAND_BITS-1:0] operand_ref;

   modport source (output valid, command, operator_code, is_right_paren, operand_ref,
                   input ready);
   modport sink   (input valid, command, operator_code, is_right_paren, operand_ref,
                   output ready);
endinterface

// ----- sv/itops_rsp_if.sv -----
// ----------------------------------------------------------------------------
// itops_rsp_if
// Postfix result channel: valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
interface itops_rsp_if;
   import itops_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [1:0]              token_kind;
   logic [3:0]              out_operator;
   logic [OPERAND_BITS-1:0] out_operand;
   logic [1:0]              error_code;
   logic                    last;

   modport source (output valid, token_kind, out_operator, out_operand, error_code, last,
                   input ready);
   modport sink   (input valid, token_kind, out_operator, out_operand, error_code, last,
                   output ready);
endinterface

// ----- sv/infix_to_postfix_operator_stack.sv -----
// ----------------------------------------------------------------------------
// infix_to_postfix_operator_stack: operator-stack infix to postfix converter.
// A token is held in the sequencer; each result passes the pending slot and then
// the output register. A new token is taken only once the sequencer is idle again,
// after all of its pops. Reset clears count and control.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_operator_stack_defines.svh"

module infix_to_postfix_operator_stack (
   input  logic         clock,
   input  logic         reset,
   itops_req_if.sink    req,
   itops_rsp_if.source  rsp
);
   import itops_pkg::*;

   stack_wr_type       wr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [3:0]         top;
   put_type            put;
   logic               can_put;
   seq_status_type     status;

   itops_stack_mem u_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (top)
   );

   itops_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .top     (top),
      .can_put (can_put),
      .wr      (wr),
      .rd_addr (rd_addr),
      .put     (put),
      .status  (status)
   );

   itops_out u_out (
      .clock   (clock),
      .reset   (reset),
      .put     (put),
      .can_put (can_put),
      .rsp     (rsp)
   );

   // Checks
   `ITOPS_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, status.count <= DEPTH_CNT)
   `ITOPS_ASSERT_IMPLY(a_push_room, clock, reset, wr.en, status.count < DEPTH_CNT)
   `ITOPS_ASSERT_NEXT(a_accept_busy, clock, reset, req.valid && req.ready, !req.ready)
   `ITOPS_ASSERT_IMPLY(a_put_busy, clock, reset, put.valid || put.close, !status.idle)

endmodule

// ----- sv/itops_stack_mem.sv -----
// ----------------------------------------------------------------------------
// itops_stack_mem
// Operator stack storage: one write port, one registered read port, with
// write-to-read forwarding when both hit the same entry in one cycle.
// ----------------------------------------------------------------------------
module itops_stack_mem (
   input  logic                          clock,
   input  itops_pkg::stack_wr_type       wr,
   input  logic [itops_pkg::ADDR_W-1:0]  rd_addr,
   output logic [3:0]                    rd_data
);
   import itops_pkg::*;

   logic [3:0] mem_ff [STACK_DEPTH];
   logic [3:0] rd_data_ff;

   // Write the pushed entry
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // Read the top entry; forward a same-cycle write
   always_ff @(posedge clock) begin
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/itops_seq.sv -----
// ----------------------------------------------------------------------------
// itops_seq
// Token sequencer: takes one token, then pops, pushes or reports against the
// stack top, one step per cycle unless output stalls, until the token is done.
// ----------------------------------------------------------------------------
module itops_seq (
   input  logic                          clock,
   input  logic                          reset,
   itops_req_if.sink                     req,
   input  logic [3:0]                    top,
   input  logic                          can_put,
   output itops_pkg::stack_wr_type       wr,
   output logic [itops_pkg::ADDR_W-1:0]  rd_addr,
   output itops_pkg::put_type            put,
   output itops_pkg::seq_status_type     status
);
   import itops_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_WORK = 2'b10
   } seq_state_type;

   seq_state_type           state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    first_ff, first_in;
   logic [1:0]              cmd_ff;
   logic [3:0]              code_ff;
   logic                    rp_ff;
   logic [OPERAND_BITS-1:0] opnd_ff;
   logic                    empty;
   logic                    full;
   logic                    pop_want;
   logic [CNT_W-1:0]        top_idx;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == DEPTH_CNT);
   assign req.ready = (state_ff == S_IDLE);

   // Decide one step against the current top
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      first_in = first_ff;
      pop_want = 1'b0;
      put      = '0;
      wr       = '0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = S_WORK;
               first_in = 1'b1;
            end
         end
         S_WORK: begin
            case (cmd_ff)
               CMD_OPERAND: begin
                  put.valid   = 1'b1;
                  put.kind    = KIND_OPERAND;
                  put.operand = opnd_ff;
                  put.fin     = 1'b1;
                  if (can_put) begin
                     state_in = S_IDLE;
                  end
               end
               CMD_OPERATOR: begin
                  if (rp_ff) begin
                     if (empty) begin
                        put.valid = 1'b1;
                        put.kind  = KIND_ERROR;
                        put.err   = first_ff ? ERR_RPAREN : ERR_NO_LPAREN;
                        put.fin   = 1'b1;
                        if (can_put) begin
                           state_in = S_IDLE;
                        end
                     end else if (top == OP_LPAREN) begin
                        // drop the matching left parenthesis
                        count_in  = count_ff - CNT_W'(1);
                        put.close = 1'b1;
                        state_in  = S_IDLE;
                     end else begin
                        pop_want = 1'b1;
                     end
                  end else if (empty || (code_ff == OP_LPAREN) ||
                               (prec_of(code_ff) <= prec_of(top))) begin
                     if (full) begin
                        put.valid = 1'b1;
                        put.kind  = KIND_ERROR;
                        put.err   = ERR_OVERFLOW;
                        put.fin   = 1'b1;
                        if (can_put) begin
                           state_in = S_IDLE;
                        end
                     end else begin
                        wr.en     = 1'b1;
                        wr.addr   = count_ff[ADDR_W-1:0];
                        wr.data   = code_ff;
                        count_in  = count_ff + CNT_W'(1);
                        put.close = 1'b1;
                        state_in  = S_IDLE;
                     end
                  end else begin
                     pop_want = 1'b1;
                  end
               end
               CMD_END: begin
                  if (empty) begin
                     put.valid = 1'b1;
                     put.kind  = KIND_END;
                     put.fin   = 1'b1;
                     if (can_put) begin
                        state_in = S_IDLE;
                     end
                  end else begin
                     pop_want = 1'b1;
                  end
               end
               default: begin
                  // unused command: nothing to do
                  put.close = 1'b1;
                  state_in  = S_IDLE;
               end
            endcase
            // Pop and emit the top entry
            if (pop_want) begin
               put.valid = 1'b1;
               put.kind  = KIND_OPERATOR;
               put.op    = top;
               put.fin   = 1'b0;
               if (can_put) begin
                  count_in = count_ff - CNT_W'(1);
                  first_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Read address follows the next top of stack
   assign top_idx = count_in - CNT_W'(1);
   assign rd_addr = (count_in == '0) ? '0 : top_idx[ADDR_W-1:0];

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         first_ff <= first_in;
      end
   end

   // Hold the accepted token
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         cmd_ff  <= req.command;
         code_ff <= req.operator_code;
         rp_ff   <= req.is_right_paren;
         opnd_ff <= req.operand_ref;
      end
   end

   assign status.idle  = (state_ff == S_IDLE);
   assign status.count = count_ff;

endmodule

// ----- sv/itops_out.sv -----
// ----------------------------------------------------------------------------
// itops_out
// Result staging: a pending slot that waits until it is known whether the
// result closes its token, then the output register toward the sink.
// ----------------------------------------------------------------------------
module itops_out (
   input  logic               clock,
   input  logic               reset,
   input  itops_pkg::put_type put,
   output logic               can_put,
   itops_rsp_if.source        rsp
);
   import itops_pkg::*;

   logic                    pend_valid_ff, pend_valid_in;
   logic                    pend_fin_ff, pend_fin_in;
   logic [1:0]              pend_kind_ff;
   logic [3:0]              pend_op_ff;
   logic [OPERAND_BITS-1:0] pend_operand_ff;
   logic [1:0]              pend_err_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_kind_ff;
   logic [3:0]              rsp_op_ff;
   logic [OPERAND_BITS-1:0] rsp_operand_ff;
   logic [1:0]              rsp_err_ff;
   logic                    rsp_last_ff;
   logic                    out_free;
   logic                    produce;
   logic                    pend_go;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign can_put  = !pend_valid_ff || out_free;
   assign produce  = put.valid && can_put;
   // Release the pending beat once its last flag is settled
   assign pend_go  = pend_valid_ff && out_free && (pend_fin_ff || put.valid);

   // Pending slot control
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_fin_in   = pend_fin_ff;
      if (produce) begin
         pend_valid_in = 1'b1;
         pend_fin_in   = put.fin;
      end else if (pend_go) begin
         pend_valid_in = 1'b0;
      end
      if (put.close) begin
         pend_fin_in = 1'b1;
      end
   end

   // Output register control
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pend_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_fin_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_fin_ff   <= pend_fin_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Load payloads
   always_ff @(posedge clock) begin
      if (produce) begin
         pend_kind_ff    <= put.kind;
         pend_op_ff      <= put.op;
         pend_operand_ff <= put.operand;
         pend_err_ff     <= put.err;
      end
      if (pend_go) begin
         rsp_kind_ff    <= pend_kind_ff;
         rsp_op_ff      <= pend_op_ff;
         rsp_operand_ff <= pend_operand_ff;
         rsp_err_ff     <= pend_err_ff;
         rsp_last_ff    <= pend_fin_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.token_kind   = rsp_kind_ff;
   assign rsp.out_operator = rsp_op_ff;
   assign rsp.out_operand  = rsp_operand_ff;
   assign rsp.error_code   = rsp_err_ff;
   assign rsp.last         = rsp_last_ff;

endmodule

// ----- sim/tb_infix_to_postfix_operator_stack.sv -----
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_operator_stack
// Self-checking bench for the operator-stack infix to postfix converter.
// A table of directed tokens covers the edge cases: errors on an empty stack,
// a missing left parenthesis, every operator and a left parenthesis still
// open at the end. Random expressions follow, mostly well formed, with deep
// nesting that can overflow the stack and some stray tokens. A shadow operator
// stack predicts the untyped beats; each beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_operator_stack;
   import itops_pkg::*;

   localparam logic [1:0] CMD_IGNORED = 2'd3;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int TOKENS_PER_PASS = 100;
   // Binding rank per operator code; lower binds tighter
   localparam int BIND_RANK [16] = '{1, 2, 2, 2, 3, 3, 4, 4, 4, 4, 5, 5, 6, 7, 8, 9};

   typedef struct packed {
      logic [1:0]              command;
      logic [3:0]              code;
      logic                    rparen;
      logic [OPERAND_BITS-1:0] operand;
   } token_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic [3:0]              op;
      logic [OPERAND_BITS-1:0] operand;
      logic [1:0]              err;
      logic                    last;
   } postfix_beat_type;

   typedef struct packed {
      logic [1:0]              command;
      logic [3:0]              code;
      logic                    rparen;
      logic [OPERAND_BITS-1:0] operand;
      logic                    typed;
      logic [1:0]              kind;
      logic [3:0]              op;
      logic [OPERAND_BITS-1:0] res_operand;
      logic [1:0]              err;
   } plan_row_type;

   // Directed tokens; typed rows carry their single expected beat
   localparam int PLAN_ROWS = 26;
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      '{CMD_OPERATOR, OP_MUL,    1'b1, 16'h0000, 1'b1, KIND_ERROR,   '0, '0,       ERR_RPAREN},
      '{CMD_OPERAND,  OP_NOT,    1'b0, 16'h0000, 1'b1, KIND_OPERAND, '0, 16'h0000, ERR_NONE},
      '{CMD_OPERAND,  OP_LPAREN, 1'b1, 16'hFFFF, 1'b1, KIND_OPERAND, '0, 16'hFFFF, ERR_NONE},
      '{CMD_END,      OP_LPAREN, 1'b1, 16'hFFFF, 1'b1, KIND_END,     '0, '0,       ERR_NONE},
      '{CMD_IGNORED,  OP_LPAREN, 1'b1, 16'hFFFF, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERAND,  OP_NOT,    1'b0, 16'h1234, 1'b1, KIND_OPERAND, '0, 16'h1234, ERR_NONE},
      '{CMD_OPERATOR, OP_ASSIGN, 1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_OR,     1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_AND,    1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_NE,     1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_EQ,     1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_GE,     1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_LE,     1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_GT,     1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_LT,     1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_SUB,    1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_ADD,    1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_MOD,    1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_DIV,    1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_MUL,    1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_NOT,    1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_NOT,    1'b1, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERATOR, OP_LPAREN, 1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_OPERAND,  OP_NOT,    1'b0, 16'h00FF, 1'b1, KIND_OPERAND, '0, 16'h00FF, ERR_NONE},
      '{CMD_OPERATOR, OP_ADD,    1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE},
      '{CMD_END,      OP_NOT,    1'b0, 16'h0000, 1'b0, '0,           '0, '0,       ERR_NONE}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   itops_req_if req_if ();
   itops_rsp_if rsp_if ();

   infix_to_postfix_operator_stack i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // Shadow of the operator stack and the postfix beats still owed
   logic [3:0]       shadow_stack [STACK_DEPTH];
   int               shadow_depth;
   postfix_beat_type step_beats [$];
   postfix_beat_type postfix_expect [$];

   int sender_idle_pct;
   int receiver_idle_pct;
   logic hold_off_request;
   int hold_off_left;

   int mismatch_count;
   int tokens_sent;
   int beats_checked;
   int peak_depth;
   int error_seen [4];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Append one predicted beat for the current token
   function automatic void add_beat(input logic [1:0] kind, input logic [3:0] op,
                                    input logic [OPERAND_BITS-1:0] operand,
                                    input logic [1:0] err);
      postfix_beat_type b;
      b.kind    = kind;
      b.op      = op;
      b.operand = operand;
      b.err     = err;
      b.last    = 1'b0;
      step_beats.push_back(b);
      if (kind == KIND_ERROR)
         error_seen[err]++;
   endfunction

   // Pop the top operator and emit it
   function automatic void pop_operator();
      shadow_depth--;
      add_beat(KIND_OPERATOR, shadow_stack[shadow_depth], '0, ERR_NONE);
   endfunction

   // Push an operator, or report overflow and drop it
   function automatic void push_operator(input logic [3:0] code);
      if (shadow_depth >= STACK_DEPTH) begin
         add_beat(KIND_ERROR, '0, '0, ERR_OVERFLOW);
      end else begin
         shadow_stack[shadow_depth] = code;
         shadow_depth++;
         if (shadow_depth > peak_depth)
            peak_depth = shadow_depth;
      end
   endfunction

   // Work out the postfix beats that one token causes
   function automatic void convert_token(input token_type t);
      int rank;
      step_beats.delete();
      case (t.command)
         CMD_OPERAND: begin
            add_beat(KIND_OPERAND, '0, t.operand, ERR_NONE);
         end
         CMD_OPERATOR: begin
            if (t.rparen) begin
               if (shadow_depth == 0) begin
                  add_beat(KIND_ERROR, '0, '0, ERR_RPAREN);
               end else begin
                  while (shadow_depth > 0 && shadow_stack[shadow_depth-1] != OP_LPAREN)
                     pop_operator();
                  if (shadow_depth == 0)
                     add_beat(KIND_ERROR, '0, '0, ERR_NO_LPAREN);
                  else
                     shadow_depth--;
               end
            end else if (shadow_depth == 0 || t.code == OP_LPAREN) begin
               push_operator(t.code);
            end else begin
               rank = BIND_RANK[t.code];
               if (rank >= BIND_RANK[shadow_stack[shadow_depth-1]]) begin
                  while (shadow_depth > 0 && rank > BIND_RANK[shadow_stack[shadow_depth-1]])
                     pop_operator();
               end
               push_operator(t.code);
            end
         end
         CMD_END: begin
            while (shadow_depth > 0)
               pop_operator();
            add_beat(KIND_END, '0, '0, ERR_NONE);
         end
         default: ;
      endcase
      if (step_beats.size() > 0)
         step_beats[step_beats.size()-1].last = 1'b1;
   endfunction

   // Offer one token, hold it until accepted, then record its beats
   task automatic send_token(input token_type t, input bit typed = 1'b0,
                             input postfix_beat_type typed_beat = '0);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.command        <= t.command;
      req_if.operator_code  <= t.code;
      req_if.is_right_paren <= t.rparen;
      req_if.operand_ref    <= t.operand;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      convert_token(t);
      if (typed) begin
         step_beats.delete();
         step_beats.push_back(typed_beat);
      end
      foreach (step_beats[i])
         postfix_expect.push_back(step_beats[i]);
      if (t.command != CMD_IGNORED)
         tokens_sent++;
   endtask

   // Build a token; fields that the command ignores get random bits
   function automatic token_type shaped_token(input logic [1:0] command,
                                              input logic [3:0] code,
                                              input logic rparen);
      token_type t;
      t.command = command;
      t.code    = 4'($urandom);
      t.rparen  = 1'($urandom);
      t.operand = OPERAND_BITS'($urandom);
      if (command == CMD_OPERATOR) begin
         t.rparen = rparen;
         if (!rparen)
            t.code = code;
      end
      return t;
   endfunction

   function automatic logic [3:0] binary_operator();
      return 4'($urandom_range(OP_MUL, OP_ASSIGN));
   endfunction

   // One random expression: mostly well formed, some deep nesting, some noise
   task automatic send_random_expression();
      int shape;
      int terms;
      int open_paren;
      token_type noise;
      shape = $urandom_range(0, 99);
      open_paren = 0;
      if (shape < 8) begin
         // Nest close to or past the stack depth to force overflow
         repeat ($urandom_range(28, 36))
            send_token(shaped_token(CMD_OPERATOR, OP_LPAREN, 1'b0));
         send_token(shaped_token(CMD_OPERAND, OP_NOT, 1'b0));
         repeat ($urandom_range(1, 3)) begin
            send_token(shaped_token(CMD_OPERATOR, binary_operator(), 1'b0));
            send_token(shaped_token(CMD_OPERAND, OP_NOT, 1'b0));
         end
         if ($urandom_range(0, 1))
            send_token(shaped_token(CMD_OPERATOR, OP_NOT, 1'b1));
         send_token(shaped_token(CMD_END, OP_NOT, 1'b0));
      end else if (shape < 18) begin
         // Stray tokens of any kind
         repeat ($urandom_range(1, 6)) begin
            noise.command = 2'($urandom);
            noise.code    = 4'($urandom);
            noise.rparen  = 1'($urandom);
            noise.operand = OPERAND_BITS'($urandom);
            send_token(noise);
         end
      end else begin
         terms = $urandom_range(1, 6);
         for (int k = 0; k < terms; k++) begin
            while ($urandom_range(0, 99) < 20) begin
               send_token(shaped_token(CMD_OPERATOR, OP_LPAREN, 1'b0));
               open_paren++;
            end
            if ($urandom_range(0, 99) < 15)
               send_token(shaped_token(CMD_OPERATOR, OP_NOT, 1'b0));
            send_token(shaped_token(CMD_OPERAND, OP_NOT, 1'b0));
            while (open_paren > 0 && $urandom_range(0, 99) < 30) begin
               send_token(shaped_token(CMD_OPERATOR, OP_NOT, 1'b1));
               open_paren--;
            end
            if (k < terms - 1)
               send_token(shaped_token(CMD_OPERATOR, binary_operator(), 1'b0));
         end
         // Close most open groups; leave some for the drain at the end
         while (open_paren > 0 && $urandom_range(0, 99) < 85) begin
            send_token(shaped_token(CMD_OPERATOR, OP_NOT, 1'b1));
            open_paren--;
         end
         if ($urandom_range(0, 99) < 6)
            send_token(shaped_token(CMD_OPERATOR, OP_NOT, 1'b1));
         send_token(shaped_token(CMD_END, OP_NOT, 1'b0));
      end
   endtask

   // Drive ready: random idling, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_if.ready  <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_request) begin
         rsp_if.ready     <= 1'b0;
         hold_off_left    <= HOLD_OFF_CYCLES;
         hold_off_request <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Check each accepted beat against the oldest expectation
   always @(posedge clock) begin
      postfix_beat_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (postfix_expect.size() == 0) begin
            $display({"%0t: unexpected beat, expected none, ",
                      "actual kind %0d op %0d operand %0d err %0d"},
                     $time, rsp_if.token_kind, rsp_if.out_operator, rsp_if.out_operand,
                     rsp_if.error_code);
            mismatch_count++;
         end else begin
            want = postfix_expect.pop_front();
            check_field("token_kind", want.kind, rsp_if.token_kind);
            check_field("out_operator", want.op, rsp_if.out_operator);
            check_field("out_operand", want.operand, rsp_if.out_operand);
            check_field("error_code", want.err, rsp_if.error_code);
            check_field("last", want.last, rsp_if.last);
            beats_checked++;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout with %0d beats outstanding", $time, postfix_expect.size());
      $display("tb_infix_to_postfix_operator_stack: FAIL");
      $finish;
   end

   initial begin
      token_type        t;
      postfix_beat_type b;
      int               pass_start;
      int               settle;

      req_if.valid          = 1'b0;
      req_if.command        = CMD_OPERAND;
      req_if.operator_code  = OP_NOT;
      req_if.is_right_paren = 1'b0;
      req_if.operand_ref    = '0;
      rsp_if.ready          = 1'b0;
      hold_off_request      = 1'b0;
      hold_off_left         = 0;
      shadow_depth          = 0;
      mismatch_count        = 0;
      tokens_sent           = 0;
      beats_checked         = 0;
      peak_depth            = 0;
      foreach (error_seen[i])
         error_seen[i] = 0;
      foreach (shadow_stack[i])
         shadow_stack[i] = OP_NOT;
      sender_idle_pct   = 11;
      receiver_idle_pct = 50;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (DIRECTED_PLAN[r]) begin
         t.command = DIRECTED_PLAN[r].command;
         t.code    = DIRECTED_PLAN[r].code;
         t.rparen  = DIRECTED_PLAN[r].rparen;
         t.operand = DIRECTED_PLAN[r].operand;
         b.kind    = DIRECTED_PLAN[r].kind;
         b.op      = DIRECTED_PLAN[r].op;
         b.operand = DIRECTED_PLAN[r].res_operand;
         b.err     = DIRECTED_PLAN[r].err;
         b.last    = 1'b1;
         send_token(t, DIRECTED_PLAN[r].typed, b);
      end

      // Random expressions in three idling passes
      for (int pass = 0; pass < 3; pass++) begin
         case (pass)
            0: begin
               sender_idle_pct   = 11;
               receiver_idle_pct = 50;
            end
            1: begin
               sender_idle_pct   = 50;
               receiver_idle_pct = 11;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
               hold_off_request <= 1'b1;
            end
         endcase
         pass_start = tokens_sent;
         while (tokens_sent < pass_start + TOKENS_PER_PASS)
            send_random_expression();
      end
      req_if.valid <= 1'b0;

      // Drain what is owed, then let the pipeline settle
      settle = 0;
      while (postfix_expect.size() > 0 && settle < 20000) begin
         @(posedge clock);
         settle++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (postfix_expect.size() > 0) begin
         $display("%0t: %0d expected beats never arrived", $time, postfix_expect.size());
         mismatch_count += postfix_expect.size();
      end

      $display("Run covered %0d tokens and %0d postfix beats, stack depth up to %0d.",
               tokens_sent, beats_checked, peak_depth);
      $display("Errors seen: %0d stray right paren, %0d missing left paren, %0d overflow.",
               error_seen[ERR_RPAREN], error_seen[ERR_NO_LPAREN], error_seen[ERR_OVERFLOW]);
      if (mismatch_count == 0) begin
         $display("tb_infix_to_postfix_operator_stack: PASS");
      end else begin
         $display("tb_infix_to_postfix_operator_stack: FAIL");
      end
      $finish;
   end

endmodule
